### rtl/core/alpn_pkg.sv
// Shared types and protocol codes for the ALPN list selector.
`timescale 1ns / 1ps

package alpn_pkg;

  localparam int unsigned TDATA_IN_W  = 8;
  localparam int unsigned TDATA_OUT_W = 24;
  localparam int unsigned MATCH_OFF_W = 16;

  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_H2   = 2'd1;
  localparam logic [1:0] PROTO_HTTP = 2'd2;

  typedef struct packed {
    logic                   list_malformed;
    logic [MATCH_OFF_W-1:0] match_offset;
    logic [1:0]             selected_protocol;
  } result_t;

endpackage

### rtl/core/alpn_list_select.sv
// Top level of the streaming ALPN protocol selector.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_axis_tvalid/tready       tdata list_byte, tlast last_byte
//   m_axis    out  m_axis_tvalid/tready       tdata result, one per list
//   cfg       in   cfg_valid/cfg_ready        h2_enable
//
// One list byte per cycle while s_axis_tready is high; the result is formed from the byte with tlast.
// Scan state lives in registers updated on each input transfer; the result is held
// in an output register backed by a one-entry skid register.
// s_axis_tready drops only while the skid register is occupied.
// Reset clears all scan state and sets h2_enable.
`timescale 1ns / 1ps

module alpn_list_select #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [alpn_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,  // [7:0] list_byte
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [1:0] selected_protocol, [17:2] match_offset, [18] list_malformed, [23:19] zero
  output logic [alpn_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i
);

  logic              h2_enable_q;
  logic              take, res_valid;
  alpn_pkg::result_t res, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;

  assign take            = s_axis_tvalid_i && s_axis_tready_o;
  assign res_valid       = take && s_axis_tlast_i;
  assign s_axis_tready_o = !skid_valid_q;
  assign cfg_ready_o     = 1'b1;

  alpn_scan #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .h2_enable_i (h2_enable_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h2_enable_q <= 1'b1;
    end else if (cfg_valid_i) begin
      h2_enable_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = alpn_pkg::TDATA_OUT_W'(out_q);

endmodule

### rtl/core/alpn_scan.sv
// Per-byte ALPN list scanner: entry tracking, name compare and selection.
`timescale 1ns / 1ps

module alpn_scan #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic              h2_enable_i,
  output alpn_pkg::result_t res_o
);

  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
  localparam logic [7:0] H2_LEN   = 8'd2;
  localparam logic [7:0] HTTP_LEN = 8'd8;
  localparam logic [7:0] H2_NAME   [2] = '{8'h68, 8'h32};
  localparam logic [7:0] HTTP_NAME [8] = '{8'h68, 8'h74, 8'h74, 8'h70,
                                           8'h2F, 8'h31, 8'h2E, 8'h31};

  logic [OFFSET_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [OFFSET_BITS-1:0] h2_off_q, h2_off_d, http_off_q, http_off_d;
  logic [7:0]             len_q, len_d, rem_q, rem_d, idx;
  logic                   h2_cand_q, h2_cand_d, http_cand_q, http_cand_d;
  logic                   h2_found_q, h2_found_d, http_found_q, http_found_d;
  logic                   broken_q, broken_d, bad;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  assign idx = len_q - rem_q;

  always_comb begin
    pos_d        = sat_inc(pos_q);
    start_d      = start_q;
    h2_off_d     = h2_off_q;
    http_off_d   = http_off_q;
    len_d        = len_q;
    rem_d        = rem_q;
    h2_cand_d    = h2_cand_q;
    http_cand_d  = http_cand_q;
    h2_found_d   = h2_found_q;
    http_found_d = http_found_q;
    broken_d     = broken_q;
    if (!broken_q) begin
      if (rem_q == 8'd0) begin
        if (byte_i == 8'd0) begin
          broken_d = 1'b1;
        end else begin
          len_d       = byte_i;
          rem_d       = byte_i;
          start_d     = sat_inc(pos_q);
          h2_cand_d   = (byte_i == H2_LEN);
          http_cand_d = (byte_i == HTTP_LEN);
        end
      end else begin
        if (idx >= H2_LEN || H2_NAME[idx[0]] != byte_i) begin
          h2_cand_d = 1'b0;
        end
        if (idx >= HTTP_LEN || HTTP_NAME[idx[2:0]] != byte_i) begin
          http_cand_d = 1'b0;
        end
        rem_d = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          if (h2_cand_d && !h2_found_q) begin
            h2_found_d = 1'b1;
            h2_off_d   = start_q;
          end
          if (http_cand_d && !http_found_q) begin
            http_found_d = 1'b1;
            http_off_d   = start_q;
          end
          h2_cand_d   = 1'b0;
          http_cand_d = 1'b0;
        end
      end
    end
  end

  assign bad = broken_d || (rem_d != 8'd0);

  always_comb begin
    res_o.list_malformed    = bad;
    res_o.selected_protocol = alpn_pkg::PROTO_NONE;
    res_o.match_offset      = '0;
    if (h2_enable_i && h2_found_d) begin
      res_o.selected_protocol = alpn_pkg::PROTO_H2;
      res_o.match_offset      = alpn_pkg::MATCH_OFF_W'(h2_off_d);
    end else if (http_found_d) begin
      res_o.selected_protocol = alpn_pkg::PROTO_HTTP;
      res_o.match_offset      = alpn_pkg::MATCH_OFF_W'(http_off_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      start_q      <= '0;
      h2_off_q     <= '0;
      http_off_q   <= '0;
      len_q        <= '0;
      rem_q        <= '0;
      h2_cand_q    <= 1'b0;
      http_cand_q  <= 1'b0;
      h2_found_q   <= 1'b0;
      http_found_q <= 1'b0;
      broken_q     <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        pos_q        <= '0;
        start_q      <= '0;
        h2_off_q     <= '0;
        http_off_q   <= '0;
        len_q        <= '0;
        rem_q        <= '0;
        h2_cand_q    <= 1'b0;
        http_cand_q  <= 1'b0;
        h2_found_q   <= 1'b0;
        http_found_q <= 1'b0;
        broken_q     <= 1'b0;
      end else begin
        pos_q        <= pos_d;
        start_q      <= start_d;
        h2_off_q     <= h2_off_d;
        http_off_q   <= http_off_d;
        len_q        <= len_d;
        rem_q        <= rem_d;
        h2_cand_q    <= h2_cand_d;
        http_cand_q  <= http_cand_d;
        h2_found_q   <= h2_found_d;
        http_found_q <= http_found_d;
        broken_q     <= broken_d;
      end
    end
  end

endmodule

### rtl/core/alpn_chk.sv
// Port-level checker for the ALPN list selector, with its bind.
`timescale 1ns / 1ps

module alpn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] == alpn_pkg::PROTO_NONE
      |-> m_axis_tdata_o[17:2] == 16'd0)
    else $error("offset nonzero with no protocol");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[23:19] == 5'd0
      && (m_axis_tdata_o[1:0] == alpn_pkg::PROTO_NONE
       || m_axis_tdata_o[1:0] == alpn_pkg::PROTO_H2
       || m_axis_tdata_o[1:0] == alpn_pkg::PROTO_HTTP))
    else $error("bad result code or padding");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

endmodule

bind alpn_list_select alpn_chk u_alpn_chk (.*);
